// ===== rtl/length_prefix_deframer_macros.svh =====
// Assertion macros shared by the length-prefix deframer RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef LENGTH_PREFIX_DEFRAMER_MACROS_SVH
`define LENGTH_PREFIX_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("length_prefix_deframer: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("length_prefix_deframer: next-cycle check failed");

`endif

// ===== rtl/lpd_pkg.sv =====
// Package for the length-prefix deframer: result codes, error codes and defaults.
// No dependencies; used by the top level and the testbench.
`timescale 1ns / 1ps

package lpd_pkg;

    localparam int unsigned MAGIC_LEN_DEFAULT = 4;
    localparam int unsigned HEADER_LEN        = 4;
    localparam logic [31:0] MAGIC_RESET       = 32'h4947_4E49;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    typedef enum logic {
        ERR_MAGIC   = 1'b0,
        ERR_NEG_LEN = 1'b1
    } t_err;

endpackage

// ===== rtl/lpd_stream_if.sv =====
// Valid/ready channel interfaces of the length-prefix deframer.
// lpd_byte_if carries received bytes in, lpd_result_if carries results out.
`timescale 1ns / 1ps

interface lpd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface lpd_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic       out_last;
    logic       error_code;

    modport source (output valid, output out_kind, output out_byte, output out_last,
                    output error_code, input ready);
    modport sink   (input valid, input out_kind, input out_byte, input out_last,
                    input error_code, output ready);
endinterface

// ===== rtl/length_prefix_deframer.sv =====
// Length-prefix deframer top level: one byte per cycle while no result waits, single result register.
// Depends on lpd_pkg, lpd_stream_if.sv and length_prefix_deframer_macros.svh.
`timescale 1ns / 1ps
`include "length_prefix_deframer_macros.svh"

// After reset the block expects MAGIC_LEN handshake bytes matching the most
// significant bytes of the magic word register; a mismatch gives one error
// result and the block then drops every byte until reset. After a match each
// frame is a 4-byte big-endian length followed by that many payload bytes,
// each delivered with a last flag; a zero length gives one empty-frame marker
// and a length with bit 31 set gives an error result and the sticky error
// state. A new byte is accepted in every cycle in which the result register
// is empty or being read out; a result left waiting in that register holds
// off the input. Write the magic word only while the block is idle.
module length_prefix_deframer #(
    parameter int unsigned MAGIC_LEN = lpd_pkg::MAGIC_LEN_DEFAULT
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [31:0]  i_cfg_wdata,
    lpd_byte_if.sink     i_in,
    lpd_result_if.source o_out
);

    localparam int unsigned MagicBits = 8 * MAGIC_LEN;
    localparam logic [1:0]  MagicLast = 2'(MAGIC_LEN - 1);
    localparam logic [1:0]  HdrLast   = 2'(lpd_pkg::HEADER_LEN - 1);

    typedef enum logic [3:0] {
        PH_MAGIC   = 4'b0001,
        PH_HEADER  = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_ERROR   = 4'b1000
    } t_phase;

    t_phase        r_phase,     n_phase;
    logic [1:0]    r_cnt,       n_cnt;
    logic [23:0]   r_gather,    n_gather;
    logic [30:0]   r_remain,    n_remain;
    logic [31:0]   r_magic;
    logic          r_out_valid, n_out_valid;
    lpd_pkg::t_kind r_kind,     n_kind;
    logic [7:0]    r_byte,      n_byte;
    logic          r_last,      n_last;
    lpd_pkg::t_err r_err,       n_err;

    logic        accept;
    logic        produce;
    logic [31:0] word;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign word       = {r_gather, i_in.in_byte};

    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_gather = r_gather;
        n_remain = r_remain;
        produce  = 1'b0;
        n_kind   = lpd_pkg::KIND_PAYLOAD;
        n_byte   = 8'd0;
        n_last   = 1'b0;
        n_err    = lpd_pkg::ERR_MAGIC;
        if (accept) begin
            unique case (r_phase)
                PH_MAGIC: begin
                    n_gather = word[23:0];
                    n_cnt    = r_cnt + 2'd1;
                    if (r_cnt == MagicLast) begin
                        n_cnt = 2'd0;
                        if (word[MagicBits-1:0] != r_magic[31 -: MagicBits]) begin
                            n_phase = PH_ERROR;
                            produce = 1'b1;
                            n_kind  = lpd_pkg::KIND_ERROR;
                            n_err   = lpd_pkg::ERR_MAGIC;
                        end else begin
                            n_phase = PH_HEADER;
                        end
                    end
                end
                PH_HEADER: begin
                    n_gather = word[23:0];
                    n_cnt    = r_cnt + 2'd1;
                    if (r_cnt == HdrLast) begin
                        n_cnt = 2'd0;
                        if (word[31]) begin
                            n_phase = PH_ERROR;
                            produce = 1'b1;
                            n_kind  = lpd_pkg::KIND_ERROR;
                            n_err   = lpd_pkg::ERR_NEG_LEN;
                        end else if (word[30:0] == 31'd0) begin
                            produce = 1'b1;
                            n_kind  = lpd_pkg::KIND_EMPTY;
                            n_last  = 1'b1;
                        end else begin
                            n_remain = word[30:0];
                            n_phase  = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    produce  = 1'b1;
                    n_kind   = lpd_pkg::KIND_PAYLOAD;
                    n_byte   = i_in.in_byte;
                    n_last   = (r_remain == 31'd1);
                    n_remain = r_remain - 31'd1;
                    if (r_remain == 31'd1) begin
                        n_phase = PH_HEADER;
                    end
                end
                PH_ERROR: begin
                    // Sticky until reset: bytes are taken and dropped.
                end
                default: begin
                    n_phase = PH_ERROR;
                end
            endcase
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (accept) begin
            n_out_valid = produce;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_MAGIC;
            r_cnt       <= 2'd0;
            r_out_valid <= 1'b0;
            r_magic     <= lpd_pkg::MAGIC_RESET;
        end else begin
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_magic <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_gather <= n_gather;
        r_remain <= n_remain;
        if (accept && produce) begin
            r_kind <= n_kind;
            r_byte <= n_byte;
            r_last <= n_last;
            r_err  <= n_err;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.out_kind   = r_kind;
    assign o_out.out_byte   = r_byte;
    assign o_out.out_last   = r_last;
    assign o_out.error_code = r_err;

    `LPD_ASSERT_NOW(a_phase_onehot, i_clk, i_rst_n, 1'b1, $onehot(r_phase))
    `LPD_ASSERT_NEXT(a_error_sticky, i_clk, i_rst_n, r_phase == PH_ERROR, r_phase == PH_ERROR)
    `LPD_ASSERT_NOW(a_payload_remain, i_clk, i_rst_n, r_phase == PH_PAYLOAD, r_remain != 31'd0)
    `LPD_ASSERT_NOW(a_cnt_gathering, i_clk, i_rst_n, r_cnt != 2'd0,
                    (r_phase == PH_MAGIC) || (r_phase == PH_HEADER))
    `LPD_ASSERT_NOW(a_nonpayload_zero, i_clk, i_rst_n,
                    r_out_valid && (r_kind != lpd_pkg::KIND_PAYLOAD), r_byte == 8'd0)

endmodule

// ===== bench/tb_length_prefix_deframer.sv =====
// Self-checking testbench for the length-prefix deframer: magic, frames and the error stop.
// Depends on lpd_pkg, lpd_stream_if.sv and the length_prefix_deframer top level.
`timescale 1ns / 1ps

module tb_length_prefix_deframer;

    localparam int unsigned HANDSHAKE_LEN = lpd_pkg::MAGIC_LEN_DEFAULT;
    localparam int unsigned CLK_PERIOD    = 12;
    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned DRAIN_CYCLES  = 4;
    localparam int unsigned PHASE_BYTES   = 360;
    localparam int unsigned HOLD_CYCLES   = 160;

    typedef enum logic [1:0] {
        ST_MAGIC   = 2'd0,
        ST_HEADER  = 2'd1,
        ST_PAYLOAD = 2'd2,
        ST_ERROR   = 2'd3
    } t_deframe_state;

    typedef struct packed {
        lpd_pkg::t_kind kind;
        logic [7:0]     data;
        logic           last;
        lpd_pkg::t_err  code;
    } t_frame_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [31:0] i_cfg_wdata;

    lpd_byte_if   in_if ();
    lpd_result_if out_if ();

    length_prefix_deframer #(
        .MAGIC_LEN (HANDSHAKE_LEN)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Prediction state, mirrored from the block's behaviour.
    logic [31:0]    cfg_magic = lpd_pkg::MAGIC_RESET;
    t_deframe_state dp_phase  = ST_MAGIC;
    logic [30:0]    dp_count  = '0;
    logic [30:0]    dp_len    = '0;
    logic [31:0]    dp_shift  = '0;

    logic [7:0]    stream_bytes[$];
    t_frame_result frame_results_due[$];

    int unsigned idle_pct    = 0;
    int unsigned stall_pct   = 0;
    int unsigned send_gap    = 0;
    int unsigned stall_left  = 0;
    int unsigned hold_left   = 0;
    int unsigned next_hold_at;
    int unsigned bytes_in    = 0;
    int unsigned cycle_count = 0;
    int unsigned error_count = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < 40)
            $display("ERROR at %0t: %s: got %0h, expected %0h", $time, what, got, want);
        error_count++;
    endtask

    // Works out what one accepted byte produces and queues it.
    function automatic void deframe_byte(input logic [7:0] b);
        t_frame_result r;
        logic [31:0]   want;
        logic [31:0]   mask;
        r = '{kind: lpd_pkg::KIND_PAYLOAD, data: 8'h00, last: 1'b0, code: lpd_pkg::ERR_MAGIC};
        case (dp_phase)
            ST_MAGIC: begin
                dp_shift = {dp_shift[23:0], b};
                dp_count = dp_count + 31'd1;
                if (dp_count == HANDSHAKE_LEN) begin
                    want     = cfg_magic >> (8 * (4 - HANDSHAKE_LEN));
                    mask     = 32'hFFFF_FFFF >> (8 * (4 - HANDSHAKE_LEN));
                    dp_count = '0;
                    if ((dp_shift & mask) != want) begin
                        r.kind   = lpd_pkg::KIND_ERROR;
                        dp_phase = ST_ERROR;
                        frame_results_due.push_back(r);
                    end else begin
                        dp_phase = ST_HEADER;
                    end
                    dp_shift = '0;
                end
            end
            ST_HEADER: begin
                dp_shift = {dp_shift[23:0], b};
                dp_count = dp_count + 31'd1;
                if (dp_count == lpd_pkg::HEADER_LEN) begin
                    dp_count = '0;
                    if (dp_shift[31]) begin
                        r.kind   = lpd_pkg::KIND_ERROR;
                        r.code   = lpd_pkg::ERR_NEG_LEN;
                        dp_phase = ST_ERROR;
                        frame_results_due.push_back(r);
                    end else if (dp_shift == 32'd0) begin
                        r.kind = lpd_pkg::KIND_EMPTY;
                        r.last = 1'b1;
                        frame_results_due.push_back(r);
                    end else begin
                        dp_len   = dp_shift[30:0];
                        dp_phase = ST_PAYLOAD;
                    end
                    dp_shift = '0;
                end
            end
            ST_PAYLOAD: begin
                dp_count = dp_count + 31'd1;
                r.data   = b;
                r.last   = (dp_count >= dp_len);
                if (r.last) begin
                    dp_count = '0;
                    dp_phase = ST_HEADER;
                end
                frame_results_due.push_back(r);
            end
            default: ;
        endcase
    endfunction

    function automatic void queue_frame(input int unsigned len);
        logic [31:0] hdr;
        hdr = len;
        for (int i = 0; i < 4; i++)
            stream_bytes.push_back(hdr[31 - 8 * i -: 8]);
        for (int unsigned i = 0; i < len; i++)
            stream_bytes.push_back(8'($urandom));
    endfunction

    // Mostly short frames, with some empty ones and a few long ones.
    function automatic int unsigned pick_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 0;
        else if (r < 70)
            return $urandom_range(1, 8);
        else if (r < 95)
            return $urandom_range(9, 64);
        else
            return $urandom_range(65, 300);
    endfunction

    task automatic write_magic(input logic [31:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        cfg_magic   = value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(posedge i_clk);
        while (stream_bytes.size() != 0 || in_if.valid || frame_results_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Sender: one transaction per accepted byte, with random gaps between bytes.
    always @(posedge i_clk) begin : drive_bytes
        logic advance;
        if (!i_rst_n) begin
            in_if.valid   <= 1'b0;
            in_if.in_byte <= '0;
            send_gap = 0;
            dp_phase = ST_MAGIC;
            dp_count = '0;
            dp_len   = '0;
            dp_shift = '0;
        end else begin
            advance = !in_if.valid || in_if.ready;
            if (in_if.valid && in_if.ready) begin
                deframe_byte(in_if.in_byte);
                bytes_in++;
            end
            if (advance) begin
                if (send_gap != 0) begin
                    send_gap--;
                    in_if.valid <= 1'b0;
                end else if (stream_bytes.size() != 0) begin
                    in_if.valid   <= 1'b1;
                    in_if.in_byte <= stream_bytes.pop_front();
                    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
                        send_gap = $urandom_range(1, 5);
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-offs, so that the result register fills and the input stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left    <= 0;
            next_hold_at <= 300;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (next_hold_at < 1200 && bytes_in >= next_hold_at) begin
            hold_left    <= HOLD_CYCLES;
            next_hold_at <= next_hold_at + 600;
        end
    end

    // Receiver: random stall bursts, and a field by field check of every result.
    always @(posedge i_clk) begin : check_results
        t_frame_result want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (frame_results_due.size() == 0) begin
                    report_mismatch("result with none expected", 32'(out_if.out_kind),
                                    32'd0);
                end else begin
                    want = frame_results_due.pop_front();
                    if (out_if.out_kind !== want.kind)
                        report_mismatch("out_kind", 32'(out_if.out_kind), 32'(want.kind));
                    if (out_if.out_byte !== want.data)
                        report_mismatch("out_byte", 32'(out_if.out_byte), 32'(want.data));
                    if (out_if.out_last !== want.last)
                        report_mismatch("out_last", 32'(out_if.out_last), 32'(want.last));
                    if (out_if.error_code !== want.code)
                        report_mismatch("error_code", 32'(out_if.error_code),
                                        32'(want.code));
                end
            end
            if (hold_left != 0) begin
                out_if.ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(0, 4);
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned queued;
        int unsigned len;
        logic [31:0] bad_len;
        logic [31:0] phase_magic[4];
        int unsigned phase_idle[4];
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        phase_magic   = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, $urandom};
        phase_idle    = '{25, 60, 10, 0};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The handshake uses the reset value, an extreme or a random word.
        case ($urandom_range(0, 2))
            0: ;
            1: write_magic($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000);
            default: write_magic($urandom);
        endcase
        for (int i = 0; i < HANDSHAKE_LEN; i++)
            stream_bytes.push_back(cfg_magic[31 - 8 * i -: 8]);

        // Directed frames: empty, then lengths one to three with extreme bytes.
        idle_pct  = 30;
        stall_pct = 30;
        queue_frame(0);
        stream_bytes.push_back(8'h00); stream_bytes.push_back(8'h00);
        stream_bytes.push_back(8'h00); stream_bytes.push_back(8'h01);
        stream_bytes.push_back(8'h00);
        stream_bytes.push_back(8'h00); stream_bytes.push_back(8'h00);
        stream_bytes.push_back(8'h00); stream_bytes.push_back(8'h02);
        stream_bytes.push_back(8'hFF); stream_bytes.push_back(8'hA5);
        stream_bytes.push_back(8'h00); stream_bytes.push_back(8'h00);
        stream_bytes.push_back(8'h00); stream_bytes.push_back(8'h03);
        stream_bytes.push_back(8'h5A); stream_bytes.push_back(8'h80);
        stream_bytes.push_back(8'h7F);
        wait_drained();

        // The magic word is only sampled during the handshake, so later writes
        // must leave the frame stream untouched.
        for (int p = 0; p < 4; p++) begin
            write_magic(phase_magic[p]);
            idle_pct  = phase_idle[p];
            stall_pct = phase_idle[p];
            queued    = 0;
            while (queued < PHASE_BYTES) begin
                len = pick_length();
                queue_frame(len);
                queued = queued + 4 + len;
            end
            wait_drained();
        end

        // A length with the sign bit set stops the block; what follows is dropped.
        bad_len = {1'b1, 31'($urandom)};
        for (int i = 0; i < 4; i++)
            stream_bytes.push_back(bad_len[31 - 8 * i -: 8]);
        repeat ($urandom_range(8, 20))
            stream_bytes.push_back(8'($urandom));
        wait_drained();
        repeat (8) @(posedge i_clk);

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
